/* sv/fed_pkg.sv */
`default_nettype none

package fed_pkg;

  // The echo store depth is a power of two, so the read index wraps by masking.
  localparam int unsigned STORE_AW    = 16;
  localparam int unsigned STORE_DEPTH = 1 << STORE_AW;

  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned GAIN_W    = 16;
  localparam int unsigned OFFSET_W  = 16;
  localparam int unsigned CFG_IDX_W = 4;
  localparam int unsigned CFG_DATA_W = 16;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [GAIN_W-1:0]          gain_t;
  typedef logic [OFFSET_W-1:0]        offset_t;
  typedef logic [STORE_AW-1:0]        store_idx_t;
  typedef logic [CFG_IDX_W-1:0]       cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0]      cfg_data_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FEEDBACK_GAIN = 4'd0,
    REG_READ_OFFSET   = 4'd1
  } cfg_reg_e;

  localparam gain_t   GAIN_RST   = 16'd32768;
  localparam offset_t OFFSET_RST = 16'd32768;

  // Reduce the offset register modulo the store depth.
  function automatic store_idx_t wrap_offset(input offset_t off);
    logic [STORE_AW+OFFSET_W-1:0] ext;
    ext = {{STORE_AW{1'b0}}, off};
    return ext[STORE_AW-1:0];
  endfunction

endpackage

`default_nettype wire

/* sv/fed_if.sv */
`default_nettype none

interface fed_in_if;
  logic             valid;
  logic             ready;
  fed_pkg::sample_t sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

interface fed_out_if;
  logic             valid;
  logic             ready;
  fed_pkg::sample_t sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

interface fed_cfg_if;
  logic               valid;
  logic               ready;
  fed_pkg::cfg_idx_t  reg_idx;
  fed_pkg::cfg_data_t wdata;

  modport source (output valid, output reg_idx, output wdata, input ready);
  modport sink   (input valid, input reg_idx, input wdata, output ready);
endinterface

`default_nettype wire

/* sv/feedback_echo_delay_line_top.sv */
`default_nettype none

// Channel  Direction  Payload                    Beat
// in_i     sink       sample_in (s16 Q1.15)      one input sample
// out_o    source     sample_out (s16 Q1.15)     one echoed sample
// cfg_i    sink       reg_idx, wdata (16 bits)   one register write
//
// One sample per cycle while the output is not stalled; a beat goes through the compute
// stage into the output register. The limit is the one-read, one-write store port pair.
// Reset clears control state only; entries not yet written since reset are masked by a
// fill count (write index plus a wrapped flag), so no clearing pass is needed.
// A stalled output holds its register; one more sample is still taken into the compute
// stage, after which the input stalls until the output drains.

module feedback_echo_delay_line_top (
  input  logic      clk_i,
  input  logic      rst_ni,
  fed_in_if.sink    in_i,
  fed_out_if.source out_o,
  fed_cfg_if.sink   cfg_i
);
  import fed_pkg::*;

  localparam logic signed [SAMPLE_W+1:0] SAT_MAX = 18'sd32767;
  localparam logic signed [SAMPLE_W+1:0] SAT_MIN = -18'sd32768;

  gain_t      gain_q;
  offset_t    offset_q;

  store_idx_t wr_idx_q;
  logic       full_q;

  logic       s1_vld_q;
  sample_t    s1_x_q;
  store_idx_t s1_w_q;
  store_idx_t s1_r_q;
  logic       s1_fill_q;

  logic       out_vld_q;
  sample_t    out_data_q;

  logic       wb_vld_q;
  store_idx_t wb_idx_q;
  sample_t    wb_data_q;

  sample_t    mem [STORE_DEPTH];
  sample_t    rd_data_q;

  logic       out_take;
  logic       s1_adv;
  logic       in_acc;
  store_idx_t rd_idx;
  logic       rd_fill;

  sample_t                    dly;
  logic signed [2*SAMPLE_W:0] prod;
  logic signed [SAMPLE_W:0]   scaled;
  logic signed [SAMPLE_W+1:0] sum;
  sample_t                    sat;

  // Configuration
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q   <= GAIN_RST;
      offset_q <= OFFSET_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.reg_idx)
        REG_FEEDBACK_GAIN: gain_q   <= gain_t'(cfg_i.wdata);
        REG_READ_OFFSET:   offset_q <= offset_t'(cfg_i.wdata);
        default: ;
      endcase
    end
  end

  // Handshakes
  assign out_take   = out_vld_q & out_o.ready;
  assign s1_adv     = s1_vld_q & (~out_vld_q | out_take);
  assign in_i.ready = ~s1_vld_q | s1_adv;
  assign in_acc     = in_i.valid & in_i.ready;

  // An entry holds data once the write index has passed it or has wrapped once.
  assign rd_idx  = wr_idx_q + wrap_offset(offset_q);
  assign rd_fill = full_q | (rd_idx < wr_idx_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_idx_q <= '0;
      full_q   <= 1'b0;
      s1_vld_q <= 1'b0;
    end else begin
      if (in_acc) begin
        wr_idx_q <= wr_idx_q + store_idx_t'(1);
        if (&wr_idx_q) begin
          full_q <= 1'b1;
        end
      end
      if (in_acc) begin
        s1_vld_q <= 1'b1;
      end else if (s1_adv) begin
        s1_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_x_q    <= in_i.sample_in;
      s1_w_q    <= wr_idx_q;
      s1_r_q    <= rd_idx;
      s1_fill_q <= rd_fill;
    end
  end

  // Echo store: read-before-write on the same edge.
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      mem[s1_w_q] <= sat;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      rd_data_q <= mem[rd_idx];
    end
  end

  // The write made on the edge that loaded the read data is not in it; take it from
  // the write-back register instead.
  always_comb begin
    if (wb_vld_q && (wb_idx_q == s1_r_q)) begin
      dly = wb_data_q;
    end else if (s1_fill_q) begin
      dly = rd_data_q;
    end else begin
      dly = '0;
    end
    prod   = $signed({{(SAMPLE_W+1){dly[SAMPLE_W-1]}}, dly}) *
             $signed({{(SAMPLE_W+1){1'b0}}, gain_q});
    // Arithmetic shift by 16 rounds toward minus infinity.
    scaled = prod[2*SAMPLE_W:GAIN_W];
    sum    = $signed({{2{s1_x_q[SAMPLE_W-1]}}, s1_x_q}) +
             $signed({scaled[SAMPLE_W], scaled});
    if (sum > SAT_MAX) begin
      sat = SAT_MAX[SAMPLE_W-1:0];
    end else if (sum < SAT_MIN) begin
      sat = SAT_MIN[SAMPLE_W-1:0];
    end else begin
      sat = sum[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      wb_vld_q  <= 1'b0;
    end else begin
      if (s1_adv) begin
        out_vld_q <= 1'b1;
        wb_vld_q  <= 1'b1;
      end else if (out_take) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_data_q <= sat;
      wb_idx_q   <= s1_w_q;
      wb_data_q  <= sat;
    end
  end

  assign out_o.valid      = out_vld_q;
  assign out_o.sample_out = out_data_q;

  // Assertions
  a_idx_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> wr_idx_q == store_idx_t'($past(wr_idx_q) + store_idx_t'(1)))
    else $error("write index did not advance by one after a beat");

  a_full_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_q |=> full_q)
    else $error("fill flag cleared without reset");

  a_s1_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_vld_q && !out_vld_q) |-> s1_adv)
    else $error("compute stage held while output register empty");

  a_wb_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> wb_vld_q && (wb_idx_q == $past(s1_w_q)) && (wb_data_q == out_data_q))
    else $error("write-back register does not match the last write");

endmodule

`default_nettype wire

/* verif/testbench.sv */
`default_nettype none

module testbench;
  import fed_pkg::*;

  localparam int IDLE_PCT    = 27;
  localparam int TAIL_CYCLES = 20;
  localparam int MAX_REPORTS = 10;
  localparam int SAMPLE_MAX  = 2 ** (SAMPLE_W - 1) - 1;
  localparam int SAMPLE_MIN  = -(2 ** (SAMPLE_W - 1));

  logic clk_i = 1'b0;
  logic rst_ni;

  fed_in_if  in_if ();
  fed_out_if out_if ();
  fed_cfg_if cfg_if ();

  feedback_echo_delay_line_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  always #5 clk_i = ~clk_i;

  // Predicted state of the echo line.
  sample_t    echo_mem [STORE_DEPTH];
  store_idx_t wr_ptr;
  gain_t      fb_gain;
  offset_t    rd_offset;
  sample_t    echo_expected [$];

  int src_idle_pct   = IDLE_PCT;
  int sink_stall_pct = IDLE_PCT;
  int n_samples;
  int n_results;
  int n_reg_writes;
  int n_saturated;
  int n_errors;

  function automatic sample_t predict_echo(input sample_t x);
    store_idx_t             rd;
    logic signed [33:0]     prod;
    logic signed [17:0]     scaled;
    int                     sum;
    rd     = store_idx_t'((longint'(wr_ptr) + longint'(rd_offset)) % STORE_DEPTH);
    prod   = echo_mem[rd] * $signed({1'b0, fb_gain});
    // Arithmetic shift floors toward minus infinity, as the datapath does.
    scaled = 18'(prod >>> 16);
    sum    = int'(x) + int'(scaled);
    if (sum > SAMPLE_MAX) begin
      sum = SAMPLE_MAX;
      n_saturated++;
    end else if (sum < SAMPLE_MIN) begin
      sum = SAMPLE_MIN;
      n_saturated++;
    end
    echo_mem[wr_ptr] = sample_t'(sum);
    wr_ptr = wr_ptr + store_idx_t'(1);
    return sample_t'(sum);
  endfunction

  function automatic void apply_reg_write(input cfg_idx_t idx, input cfg_data_t data);
    case (idx)
      REG_FEEDBACK_GAIN: fb_gain = gain_t'(data);
      REG_READ_OFFSET:   rd_offset = offset_t'(data);
      default: ;
    endcase
  endfunction

  function automatic void note_error(input string msg);
    n_errors++;
    if (n_errors <= MAX_REPORTS) $display("ERROR: %s", msg);
  endfunction

  function automatic void check_result(input sample_t got);
    sample_t want;
    if (echo_expected.size() == 0) begin
      note_error($sformatf("sample_out %0d arrived with nothing expected", got));
    end else begin
      want = echo_expected.pop_front();
      n_results++;
      if (got !== want)
        note_error($sformatf("result %0d: sample_out expected %0d, got %0d",
                             n_results, want, got));
    end
  endfunction

  // Register writes, input beats and output beats are all observed at the same edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_if.valid && cfg_if.ready) apply_reg_write(cfg_if.reg_idx, cfg_if.wdata);
      if (in_if.valid && in_if.ready) begin
        echo_expected = {echo_expected, predict_echo(in_if.sample_in)};
        n_samples++;
      end
      if (out_if.valid && out_if.ready) check_result(out_if.sample_out);
    end
  end

  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      out_if.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  task automatic set_pressure(input int pct);
    src_idle_pct   = pct;
    sink_stall_pct = pct;
  endtask

  // Leaves valid high so that back-to-back beats need no second assignment in one step.
  task automatic send_sample(input sample_t s);
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.sample_in <= s;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (echo_expected.size() != 0);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input cfg_data_t data);
    cfg_if.valid   <= 1'b1;
    cfg_if.reg_idx <= idx;
    cfg_if.wdata   <= data;
    do @(posedge clk_i); while (!cfg_if.ready);
    n_reg_writes++;
  endtask

  task automatic set_echo(input gain_t g, input offset_t off);
    write_reg(REG_FEEDBACK_GAIN, cfg_data_t'(g));
    write_reg(REG_READ_OFFSET, cfg_data_t'(off));
    cfg_if.valid <= 1'b0;
  endtask

  function automatic sample_t pick_sample();
    int roll;
    roll = $urandom_range(99);
    if (roll < 5) return sample_t'(SAMPLE_MAX);
    if (roll < 10) return sample_t'(SAMPLE_MIN);
    if (roll < 40) return sample_t'(int'($urandom_range(1023)) - 512);
    return sample_t'($urandom);
  endfunction

  function automatic gain_t pick_gain();
    case ($urandom_range(4))
      0:       return '0;
      1:       return '1;
      2:       return GAIN_RST;
      default: return gain_t'($urandom);
    endcase
  endfunction

  // Offsets just below the store depth give short echoes that land on fresh data.
  function automatic offset_t pick_offset();
    case ($urandom_range(5))
      0:       return '0;
      1:       return '1;
      2, 3:    return offset_t'(STORE_DEPTH - $urandom_range(64, 1));
      4:       return offset_t'(STORE_DEPTH - $urandom_range(2000, 65));
      default: return offset_t'($urandom);
    endcase
  endfunction

  // Reset settings point the read far ahead, so the first samples see an empty store.
  task automatic test_reset_state();
    send_sample(sample_t'(SAMPLE_MAX));
    send_sample(sample_t'(SAMPLE_MIN));
    send_sample('0);
    send_sample('1);
  endtask

  task automatic test_feedback_saturation();
    wait_drained();
    set_echo('1, '1);
    repeat (3) send_sample(sample_t'(SAMPLE_MAX));
    repeat (3) send_sample(sample_t'(SAMPLE_MIN));
    send_sample(sample_t'(1));
    send_sample('1);
  endtask

  task automatic test_zero_gain_same_slot();
    wait_drained();
    set_echo('0, '0);
    send_sample(sample_t'(SAMPLE_MAX));
    repeat (3) send_sample(pick_sample());
  endtask

  task automatic test_unused_reg_index();
    wait_drained();
    write_reg(REG_FEEDBACK_GAIN, cfg_data_t'(GAIN_RST));
    write_reg(REG_READ_OFFSET, cfg_data_t'('1));
    for (int i = 0; i < 2 ** CFG_IDX_W; i++) begin
      if (cfg_idx_t'(i) != REG_FEEDBACK_GAIN && cfg_idx_t'(i) != REG_READ_OFFSET)
        write_reg(cfg_idx_t'(i), cfg_data_t'($urandom));
    end
    cfg_if.valid <= 1'b0;
    repeat (4) send_sample(pick_sample());
  endtask

  task automatic test_random_settings(input int phases, input int per_phase,
                                      input int calm_phase);
    for (int p = 0; p < phases; p++) begin
      wait_drained();
      set_echo(pick_gain(), pick_offset());
      set_pressure((p == calm_phase) ? 0 : IDLE_PCT);
      repeat (per_phase) send_sample(pick_sample());
    end
    set_pressure(IDLE_PCT);
  endtask

  initial begin
    rst_ni          <= 1'b0;
    in_if.valid     <= 1'b0;
    in_if.sample_in <= '0;
    cfg_if.valid    <= 1'b0;
    cfg_if.reg_idx  <= REG_FEEDBACK_GAIN;
    cfg_if.wdata    <= '0;
    foreach (echo_mem[i]) echo_mem[i] = '0;
    wr_ptr    = '0;
    fb_gain   = GAIN_RST;
    rd_offset = OFFSET_RST;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_reset_state();
    test_feedback_saturation();
    test_zero_gain_same_slot();
    test_unused_reg_index();
    test_random_settings(7, 80, 3);
    test_random_settings(5, 80, -1);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("Checked %0d of %0d samples across %0d register writes and random stalls.",
             n_results, n_samples, n_reg_writes);
    $display("%0d sums clipped at full scale; %0d failures seen.", n_saturated, n_errors);
    if (n_errors == 0 && echo_expected.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Run timed out with %0d results outstanding.", echo_expected.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

`default_nettype wire

/* files.f */
sv/fed_pkg.sv
sv/fed_if.sv
sv/feedback_echo_delay_line_top.sv
verif/testbench.sv
